// ===== rtl/quadrature_encoder_speed_meter_assert.svh =====
// ----------------------------------------------------------------------------
// Quadrature encoder speed meter assertion macros
// Shared assertion forms for the controller and datapath modules.
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_ENCODER_SPEED_METER_ASSERT_SVH
`define QUADRATURE_ENCODER_SPEED_METER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define QESM_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define QESM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/qesm_pkg.sv =====
// ----------------------------------------------------------------------------
// Quadrature encoder speed meter package
// Shared constants, command and status types and saturation helpers.
// ----------------------------------------------------------------------------
package qesm_pkg;

   // Default channel count
   localparam int NUM_ENCODERS_DEF = 2;

   // Register file
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATE_SCALE     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_SCALE    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISTANCE_SCALE = 2'd2;

   localparam logic [CSR_DATA_W-1:0] RATE_SCALE_RST     = 16'd3001;
   localparam logic [CSR_DATA_W-1:0] SPEED_SCALE_RST    = 16'd5469;
   localparam logic [CSR_DATA_W-1:0] DISTANCE_SCALE_RST = 16'd4456;

   // Field widths
   localparam int CHAN_W  = 3;
   localparam int COUNT_W = 16;
   localparam int RATE_W  = 32;
   localparam int SUM_W   = 48;
   localparam int PROD_W  = 49;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 168;

   // Shared multiplier operand select
   typedef enum logic [1:0] {
      MUL_NONE,
      MUL_COUNT,
      MUL_SPEED,
      MUL_DIST
   } mul_sel_type;

   // Controller to datapath commands
   typedef struct packed {
      logic        edge_apply;
      mul_sel_type mul_sel;
      logic        cap_rate;
      logic        cap_speed;
      logic        commit;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic out_free;
   } status_type;

   // Clamp a 49-bit signed value to 48 bits
   function automatic logic signed [SUM_W-1:0] sat_48(input logic signed [PROD_W-1:0] v);
      logic signed [SUM_W-1:0] r;
      if (v[PROD_W-1] != v[SUM_W-1]) begin
         r = v[PROD_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         r = v[SUM_W-1:0];
      end
      return r;
   endfunction

   // Clamp a 49-bit signed value to 32 bits
   function automatic logic signed [RATE_W-1:0] sat_32(input logic signed [PROD_W-1:0] v);
      logic signed [RATE_W-1:0] r;
      if ((&v[PROD_W-1:RATE_W-1]) || !(|v[PROD_W-1:RATE_W-1])) begin
         r = v[RATE_W-1:0];
      end else begin
         r = v[PROD_W-1] ? {1'b1, {(RATE_W-1){1'b0}}} : {1'b0, {(RATE_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

// ===== rtl/quadrature_encoder_speed_meter.sv =====
// ----------------------------------------------------------------------------
// Quadrature encoder speed meter
// Multi-channel 2x quadrature counter with per-period rate, speed,
// revolution and distance accumulation in fixed point.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake          Payload
// req       in   req_tvalid/tready  tdata: channel, edges, levels; tuser: kind
// rsp       out  rsp_tvalid/tready  tdata: channel, rate, speed, sums; tlast
// csr       in   csr_we             csr_index, csr_wdata
//
// An edge event is applied in the cycle it is accepted. A period tick walks
// every channel through the MUL_COUNT, MUL_SPEED, MUL_DIST and WRITE states,
// using one shared 32x17 multiplier three times per channel plus a write-back
// state. The input is not taken during a walk. A stalled result holds the walk
// in its write-back state. Reset is synchronous; it clears counts and sums and
// loads the default scales.
// ----------------------------------------------------------------------------
module quadrature_encoder_speed_meter #(
   parameter int NUM_ENCODERS = qesm_pkg::NUM_ENCODERS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // bits: [2:0] channel, [3] a_rose, [4] b_rose, [5] a_level, [6] b_level
   input  logic [qesm_pkg::REQ_DATA_W-1:0]     req_tdata,
   // bits: [0] kind
   input  logic                                req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // bits: [2:0] out_channel, [34:3] rev_rate, [66:35] speed_cms,
   //       [114:67] rev_total, [162:115] distance_m
   output logic [qesm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_we,
   input  logic [qesm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [qesm_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int IDX_W = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;

   qesm_pkg::cmd_type    cmd;
   qesm_pkg::status_type status;
   logic [IDX_W-1:0]     walk_idx;
   logic                 walk_last;

   qesm_ctrl #(
      .NUM_ENCODERS (NUM_ENCODERS),
      .IDX_W        (IDX_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .status     (status),
      .cmd        (cmd),
      .walk_idx   (walk_idx),
      .walk_last  (walk_last)
   );

   qesm_dp #(
      .NUM_ENCODERS (NUM_ENCODERS),
      .IDX_W        (IDX_W)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .walk_idx     (walk_idx),
      .walk_last    (walk_last),
      .edge_channel (req_tdata[2:0]),
      .a_rose       (req_tdata[3]),
      .b_rose       (req_tdata[4]),
      .a_level      (req_tdata[5]),
      .b_level      (req_tdata[6]),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast)
   );

endmodule

// ===== rtl/qesm_ctrl.sv =====
// ----------------------------------------------------------------------------
// Quadrature encoder speed meter controller
// Sequences the tick walk over channels through the shared multiplier.
// ----------------------------------------------------------------------------
`include "quadrature_encoder_speed_meter_assert.svh"

module qesm_ctrl #(
   parameter int NUM_ENCODERS = qesm_pkg::NUM_ENCODERS_DEF,
   parameter int IDX_W        = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 req_kind,
   input  qesm_pkg::status_type status,
   output qesm_pkg::cmd_type    cmd,
   output logic [IDX_W-1:0]     walk_idx,
   output logic                 walk_last
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_COUNT,
      ST_MUL_SPEED,
      ST_MUL_DIST,
      ST_WRITE
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign walk_idx   = idx_ff;
   assign walk_last  = (idx_ff == IDX_W'(NUM_ENCODERS - 1));

   // Decode commands and next state
   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      cmd.edge_apply = 1'b0;
      cmd.mul_sel    = qesm_pkg::MUL_NONE;
      cmd.cap_rate   = 1'b0;
      cmd.cap_speed  = 1'b0;
      cmd.commit     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind) begin
                  state_in = ST_MUL_COUNT;
                  idx_in   = '0;
               end else begin
                  cmd.edge_apply = 1'b1;
               end
            end
         end
         ST_MUL_COUNT: begin
            cmd.mul_sel = qesm_pkg::MUL_COUNT;
            state_in    = ST_MUL_SPEED;
         end
         ST_MUL_SPEED: begin
            cmd.mul_sel  = qesm_pkg::MUL_SPEED;
            cmd.cap_rate = 1'b1;
            state_in     = ST_MUL_DIST;
         end
         ST_MUL_DIST: begin
            cmd.mul_sel   = qesm_pkg::MUL_DIST;
            cmd.cap_speed = 1'b1;
            state_in      = ST_WRITE;
         end
         ST_WRITE: begin
            // Hold until the output register can take the beat
            if (status.out_free) begin
               cmd.commit = 1'b1;
               if (walk_last) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_MUL_COUNT;
                  idx_in   = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   `QESM_ASSERT_SAME(a_commit_needs_slot, clock, reset, cmd.commit, status.out_free, "commit without free output slot")
   `QESM_ASSERT_NEXT(a_last_commit_idle, clock, reset, cmd.commit && walk_last, req_tready, "walk did not end after final channel")

endmodule

// ===== rtl/qesm_dp.sv =====
// ----------------------------------------------------------------------------
// Quadrature encoder speed meter datapath
// Channel state, configuration registers, shared multiplier and output stage.
// ----------------------------------------------------------------------------
`include "quadrature_encoder_speed_meter_assert.svh"

module qesm_dp #(
   parameter int NUM_ENCODERS = qesm_pkg::NUM_ENCODERS_DEF,
   parameter int IDX_W        = 1
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  qesm_pkg::cmd_type                        cmd,
   output qesm_pkg::status_type                     status,
   input  logic [IDX_W-1:0]                         walk_idx,
   input  logic                                     walk_last,
   input  logic [qesm_pkg::CHAN_W-1:0]              edge_channel,
   input  logic                                     a_rose,
   input  logic                                     b_rose,
   input  logic                                     a_level,
   input  logic                                     b_level,
   input  logic                                     csr_we,
   input  logic [qesm_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  logic [qesm_pkg::CSR_DATA_W-1:0]          csr_wdata,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   output logic [qesm_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   output logic                                     rsp_tlast
);

   localparam int CW = qesm_pkg::COUNT_W;
   localparam int RW = qesm_pkg::RATE_W;
   localparam int SW = qesm_pkg::SUM_W;
   localparam int PW = qesm_pkg::PROD_W;
   localparam int DW = qesm_pkg::CSR_DATA_W;

   // Configuration registers
   logic [DW-1:0] rate_scale_ff, speed_scale_ff, distance_scale_ff;

   // Channel state
   logic signed [CW-1:0] pulse_count_ff [NUM_ENCODERS];
   logic signed [SW-1:0] rev_sum_ff     [NUM_ENCODERS];
   logic signed [SW-1:0] distance_sum_ff[NUM_ENCODERS];

   // Work registers
   logic signed [PW-1:0] prod_ff;
   logic signed [RW-1:0] rate_ff;
   logic signed [RW-1:0] speed_ff;
   logic signed [SW-1:0] rev_new_ff;

   // Output register
   logic                           out_valid_ff;
   logic [qesm_pkg::RSP_DATA_W-1:0] out_data_ff;
   logic                           out_last_ff;

   logic                 edge_hit;
   logic [IDX_W-1:0]     edge_idx;
   logic signed [CW:0]   count_sum;
   logic signed [CW-1:0] count_in;
   logic signed [1:0]    delta;
   logic signed [RW-1:0] mul_a;
   logic signed [DW:0]   mul_b;
   logic signed [PW-1:0] prod_in;
   logic signed [PW-1:0] speed_rnd;
   logic signed [PW-1:0] step_rnd;
   logic signed [PW-1:0] rev_acc;
   logic signed [PW-1:0] dist_acc;
   logic signed [SW-1:0] dist_new;
   logic [qesm_pkg::CHAN_W-1:0] out_chan;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_scale_ff     <= qesm_pkg::RATE_SCALE_RST;
         speed_scale_ff    <= qesm_pkg::SPEED_SCALE_RST;
         distance_scale_ff <= qesm_pkg::DISTANCE_SCALE_RST;
      end else if (csr_we) begin
         case (csr_index)
            qesm_pkg::CSR_RATE_SCALE:     rate_scale_ff     <= csr_wdata;
            qesm_pkg::CSR_SPEED_SCALE:    speed_scale_ff    <= csr_wdata;
            qesm_pkg::CSR_DISTANCE_SCALE: distance_scale_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Edge decode: A wins when both rose
   always_comb begin
      if (a_rose) begin
         delta = b_level ? -2'sd1 : 2'sd1;
      end else if (b_rose) begin
         delta = a_level ? 2'sd1 : -2'sd1;
      end else begin
         delta = 2'sd0;
      end
   end

   assign edge_hit  = ({1'b0, edge_channel} < (qesm_pkg::CHAN_W + 1)'(NUM_ENCODERS));
   assign edge_idx  = IDX_W'(edge_channel);
   assign count_sum = {pulse_count_ff[edge_idx][CW-1], pulse_count_ff[edge_idx]}
                      + (CW + 1)'(delta);

   // Saturate the count at the 16-bit signed range
   always_comb begin
      if (count_sum[CW] != count_sum[CW-1]) begin
         count_in = count_sum[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end else begin
         count_in = count_sum[CW-1:0];
      end
   end

   // Shared multiplier operands
   always_comb begin
      case (cmd.mul_sel)
         qesm_pkg::MUL_COUNT: begin
            mul_a = RW'(pulse_count_ff[walk_idx]);
            mul_b = {1'b0, rate_scale_ff};
         end
         qesm_pkg::MUL_SPEED: begin
            mul_a = prod_ff[RW-1:0];
            mul_b = {1'b0, speed_scale_ff};
         end
         qesm_pkg::MUL_DIST: begin
            mul_a = rate_ff;
            mul_b = {1'b0, distance_scale_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = PW'(mul_a * mul_b);

   // Round half up, then shift
   assign speed_rnd = (prod_ff + PW'(128)) >>> 8;
   assign step_rnd  = (prod_ff + PW'(32768)) >>> 16;
   assign rev_acc   = PW'(rev_sum_ff[walk_idx]) + PW'(rate_ff);
   assign dist_acc  = PW'(distance_sum_ff[walk_idx]) + step_rnd;
   assign dist_new  = qesm_pkg::sat_48(dist_acc);
   assign out_chan  = qesm_pkg::CHAN_W'(walk_idx);

   // Multiplier and intermediate results
   always_ff @(posedge clock) begin
      if (cmd.mul_sel != qesm_pkg::MUL_NONE) begin
         prod_ff <= prod_in;
      end
      if (cmd.cap_rate) begin
         rate_ff <= prod_ff[RW-1:0];
      end
      if (cmd.cap_speed) begin
         speed_ff   <= qesm_pkg::sat_32(speed_rnd);
         rev_new_ff <= qesm_pkg::sat_48(rev_acc);
      end
   end

   // Channel state updates
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_ENCODERS; i++) begin
            pulse_count_ff[i]  <= '0;
            rev_sum_ff[i]      <= '0;
            distance_sum_ff[i] <= '0;
         end
      end else if (cmd.edge_apply && edge_hit) begin
         pulse_count_ff[edge_idx] <= count_in;
      end else if (cmd.commit) begin
         pulse_count_ff[walk_idx]  <= '0;
         rev_sum_ff[walk_idx]      <= rev_new_ff;
         distance_sum_ff[walk_idx] <= dist_new;
      end
   end

   // Output register: load on commit, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_data_ff <= {5'd0, dist_new, rev_new_ff, speed_ff, rate_ff, out_chan};
         out_last_ff <= walk_last;
      end
   end

   assign status.out_free = !out_valid_ff || rsp_tready;
   assign rsp_tvalid      = out_valid_ff;
   assign rsp_tdata       = out_data_ff;
   assign rsp_tlast       = out_last_ff;

   `QESM_ASSERT_NEXT(a_commit_shows_beat, clock, reset, cmd.commit, out_valid_ff, "committed result not presented")
   `QESM_ASSERT_SAME(a_no_edge_in_walk, clock, reset, cmd.edge_apply, cmd.mul_sel == qesm_pkg::MUL_NONE && !cmd.commit, "edge applied during channel walk")

endmodule
